FILE: rtl/tone_curve_s_knee_defines.svh
// assertion macros used by the bound checker tcsk_checker
`ifndef TONE_CURVE_S_KNEE_DEFINES_SVH
`define TONE_CURVE_S_KNEE_DEFINES_SVH

// condition that must hold at every edge out of reset
`define TCSK_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define TCSK_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence a fixed number of edges later
`define TCSK_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcsk_pkg.sv
package tcsk_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
        logic       last_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_out;
    } result_t;

    // live curve settings handed to every lane
    typedef struct packed {
        logic signed [15:0] contrast_gain;
        logic [15:0]        knee_point;
    } cfg_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CONTRAST_GAIN = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KNEE_POINT    = 4'd1;

    localparam logic signed [15:0] CONTRAST_RESET = 16'sd0;
    localparam logic [15:0]        KNEE_RESET     = 16'd52429;

    // contrast gain is Q3.12
    localparam int GAIN_FRAC = 12;

endpackage

FILE: rtl/tcsk_div.sv
module tcsk_div
#(
    parameter int FRAC_BITS = 24,
    parameter int SIDE_W    = 28
)
(
    input  logic                       clk,
    input  logic [2*FRAC_BITS+1:0]     num,
    input  logic [FRAC_BITS+1:0]       den,
    input  logic [SIDE_W-1:0]          side,
    output logic [FRAC_BITS:0]         quo,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int QB = FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 2;

    // one quotient bit per stage; low numerator bits shift out as quotient bits shift in
    logic [RW-1:0]     rem_reg  [QB];
    logic [QB-1:0]     mix_reg  [QB];
    logic [RW-1:0]     den_reg  [QB];
    logic [SIDE_W-1:0] side_reg [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [RW-1:0]     rem_in;
        logic [QB-1:0]     mix_in;
        logic [RW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW:0]       trial;
        logic [RW:0]       diff;
        logic              ge;
        logic [RW-1:0]     rem_next;
        logic [QB-1:0]     mix_next;

        if (g == 0) begin : g_first
            // quotient fits QB bits, so the top bits start below the divisor
            assign rem_in  = {1'b0, num[NW-1:QB]};
            assign mix_in  = num[QB-1:0];
            assign den_in  = den;
            assign side_in = side;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign mix_in  = mix_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        always_comb
        begin
            trial    = {rem_in, mix_in[QB-1]};
            diff     = trial - {1'b0, den_in};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
            mix_next = {mix_in[QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            mix_reg[g]  <= mix_next;
            den_reg[g]  <= den_in;
            side_reg[g] <= side_in;
        end
    end

    assign quo      = mix_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule

FILE: rtl/tcsk_lane.sv
module tcsk_lane
    import tcsk_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic       clk,
    input  logic [7:0] chan,
    input  cfg_t       cfg,
    output logic [7:0] mapped
);

    localparam int W = FRAC_BITS;

    localparam logic [63:0] ONE64   = 64'd1 << W;
    localparam logic [63:0] HALF64  = 64'd1 << (W - 1);
    localparam logic [63:0] RECIP64 = ONE64 / 64'd255;
    localparam logic [63:0] RMOD64  = ONE64 % 64'd255;

    localparam logic [W:0]   ONE   = ONE64[W:0];
    localparam logic [W:0]   HALF  = HALF64[W:0];
    localparam logic [W-1:0] RECIP = RECIP64[W-1:0];
    localparam logic [7:0]   RMOD  = RMOD64[7:0];

    logic signed [15:0] gain;
    logic [W-1:0]       knee_w;

    assign gain   = $signed(cfg.contrast_gain);
    assign knee_w = W'(cfg.knee_point) << (W - 16);

    // byte to fraction: ceil(v*one/255) = v*RECIP + ceil(v*RMOD/255)
    logic [15:0]  rem_prod;
    logic [15:0]  rem_bias;
    logic [15:0]  rem_fix;
    logic [W+8:0] scaled;
    logic [W:0]   t1_next;
    logic [W:0]   t1_reg;

    always_comb
    begin
        rem_prod = 16'(chan) * 16'(RMOD);
        rem_bias = rem_prod + 16'd254;
        // exact /255 for values below 65280, where the 16-bit sum cannot wrap
        rem_fix  = rem_bias + 16'd1 + (rem_bias >> 8);
        scaled   = (W+9)'(chan) * (W+9)'(RECIP) + (W+9)'(rem_fix[15:8]);
        t1_next  = scaled[W:0];
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= t1_next;
    end

    // t*(1-t)
    logic [W:0]       omt;
    logic [2*W+1:0]   prod2;
    logic [W-1:0]     p2_next;
    logic [W-1:0]     p2_reg;
    logic [W:0]       t2_reg;

    always_comb
    begin
        omt     = ONE - t1_reg;
        prod2   = (2*W+2)'(t1_reg) * (2*W+2)'(omt);
        p2_next = prod2[2*W-1:W];
    end

    always_ff @(posedge clk)
    begin
        p2_reg <= p2_next;
        t2_reg <= t1_reg;
    end

    // times (t - half), truncated toward zero
    logic signed [W:0]     p_s;
    logic signed [W+1:0]   th;
    logic signed [2*W+2:0] pq;
    logic signed [2*W+2:0] pq_adj;
    logic signed [W-1:0]   q3_next;
    logic signed [W-1:0]   q3_reg;
    logic [W:0]            t3_reg;

    always_comb
    begin
        p_s     = $signed({1'b0, p2_reg});
        th      = $signed({1'b0, t2_reg}) - $signed({1'b0, HALF});
        pq      = p_s * th;
        pq_adj  = pq + $signed({{(W+3){1'b0}}, {W{pq[2*W+2]}}});
        q3_next = pq_adj[2*W-1:W];
    end

    always_ff @(posedge clk)
    begin
        q3_reg <= q3_next;
        t3_reg <= t2_reg;
    end

    // gain term and curve value
    logic signed [W+15:0] cq;
    logic signed [W+15:0] cq_adj;
    logic signed [W+2:0]  term;
    logic signed [W+2:0]  s4_next;
    logic signed [W+2:0]  s4_reg;

    always_comb
    begin
        cq      = gain * q3_reg;
        cq_adj  = cq + $signed({{(W+16-GAIN_FRAC){1'b0}}, {GAIN_FRAC{cq[W+15]}}});
        term    = cq_adj[W+GAIN_FRAC+2:GAIN_FRAC];
        s4_next = $signed({2'b00, t3_reg}) + term;
    end

    always_ff @(posedge clk)
    begin
        s4_reg <= s4_next;
    end

    // knee operands for the divider
    logic                gt5_next;
    logic [W+1:0]        over;
    logic [W:0]          omk;
    logic [2*W+1:0]      num5_next;
    logic [W+1:0]        den5_next;
    logic                gt5_reg;
    logic signed [W+2:0] s5_reg;
    logic [2*W+1:0]      num5_reg;
    logic [W+1:0]        den5_reg;

    always_comb
    begin
        gt5_next  = (s4_reg > $signed({3'b000, knee_w}));
        over      = s4_reg[W+1:0] - {2'b00, knee_w};
        omk       = ONE - {1'b0, knee_w};
        num5_next = (2*W+2)'(over) * (2*W+2)'(omk);
        den5_next = {1'b0, omk} + over;
    end

    always_ff @(posedge clk)
    begin
        gt5_reg  <= gt5_next;
        s5_reg   <= s4_reg;
        num5_reg <= num5_next;
        den5_reg <= den5_next;
    end

    logic [W:0]   quo;
    logic [W+3:0] side_d;

    tcsk_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (W + 4)
    ) u_div (
        .clk      (clk),
        .num      (num5_reg),
        .den      (den5_reg),
        .side     ({gt5_reg, s5_reg}),
        .quo      (quo),
        .side_out (side_d)
    );

    // compress above the knee, clamp, back to a byte
    logic signed [W+2:0] sel;
    logic [W:0]          sc;
    logic [W+8:0]        x255;

    always_comb
    begin
        if (side_d[W+3])
            sel = $signed({2'b00, 1'b0, knee_w}) + $signed({2'b00, quo});
        else
            sel = $signed(side_d[W+2:0]);

        if (sel[W+2])
            sc = '0;
        else if (sel > $signed({2'b00, ONE}))
            sc = ONE;
        else
            sc = sel[W:0];

        x255   = {sc, 8'd0} - (W+9)'(sc);
        mapped = x255[W+7:W];
    end

endmodule

FILE: rtl/tone_curve_s_knee.sv
// tone_curve_s_knee: S-curve tone map with a soft highlight knee on RGBA pixels
//
// pixel channel: a pixel is taken at each rising edge with start high and busy
// low. busy never rises, so a new pixel may be offered on every clock.
// R, G and B each run through their own lane; alpha and last travel alongside.
//
// result channel: result_valid is high for one cycle per pixel with the mapped
// pixel on result; the transfer happens at the edge that ends that cycle.
// the receiver cannot stall, results come out in input order.
//
// pipeline: five curve stages, FRAC_BITS+1 knee divider stages (one
// quotient bit each) and the output register lie between start transfer
// and result transfer.
// throughput: one pixel per clock, every cycle.
//
// configuration: cfg_valid/cfg_ready carry cfg_index and cfg_data; cfg_ready
// is always high. index 0 is contrast_gain, index 1 knee_point, other
// indices are dropped. write only while no pixel is in flight.
// reset: contrast_gain clears to zero, knee_point goes to 52429, the pipe
// empties; results in flight at reset are lost.
module tone_curve_s_knee
    import tcsk_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pixel_t                 pixel,
    output logic                   result_valid,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LAT = FRAC_BITS + 6;

    logic accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CONTRAST_GAIN: cfg_next.contrast_gain = $signed(cfg_data);
                REG_KNEE_POINT:    cfg_next.knee_point    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contrast_gain <= CONTRAST_RESET;
            cfg_reg.knee_point    <= KNEE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    logic [7:0] red_map;
    logic [7:0] green_map;
    logic [7:0] blue_map;

    tcsk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
        .clk    (clk),
        .chan   (pixel.red_in),
        .cfg    (cfg_reg),
        .mapped (red_map)
    );

    tcsk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
        .clk    (clk),
        .chan   (pixel.green_in),
        .cfg    (cfg_reg),
        .mapped (green_map)
    );

    tcsk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
        .clk    (clk),
        .chan   (pixel.blue_in),
        .cfg    (cfg_reg),
        .mapped (blue_map)
    );

    // transfer marks and pass-through alpha and last, matched to the lane depth
    logic       valid_reg [LAT];
    logic [8:0] tag_reg   [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int i = 1; i < LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= {pixel.alpha_in, pixel.last_in};
        for (int i = 1; i < LAT; i++)
            tag_reg[i] <= tag_reg[i-1];
    end

    // merge the three lanes with the side data
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;

    always_comb
    begin
        result_next.red_out   = red_map;
        result_next.green_out = green_map;
        result_next.blue_out  = blue_map;
        result_next.alpha_out = tag_reg[LAT-1][8:1];
        result_next.last_out  = tag_reg[LAT-1][0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= valid_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/tcsk_checker.sv
`include "tone_curve_s_knee_defines.svh"

module tcsk_checker
    import tcsk_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input pixel_t  pixel,
    input logic    result_valid,
    input result_t result
);

    // edges from start transfer to result transfer
    localparam int RES_DLY = FRAC_BITS + 7;

    `TCSK_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised on a fully pipelined block")

    `TCSK_ASSERT_DELAY(a_result_follows, start && !busy, RES_DLY, result_valid, "pixel transfer gave no result")

    `TCSK_ASSERT_IMPLY(a_no_spurious, result_valid, $past(start && !busy, RES_DLY), "result without a matching pixel transfer")

    `TCSK_ASSERT_DELAY(a_side_passes, start && !busy, RES_DLY, (result.alpha_out == $past(pixel.alpha_in, RES_DLY)) && (result.last_out == $past(pixel.last_in, RES_DLY)), "alpha or last not carried through")

endmodule

bind tone_curve_s_knee tcsk_checker #(.FRAC_BITS(FRAC_BITS)) u_tcsk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result       (result)
);

FILE: tb/tone_curve_s_knee_checker.sv
module tone_curve_s_knee_checker
    import tcsk_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  pixel_t                 pixel,
    input  logic                   result_valid,
    input  result_t                result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     in_flight
);

    localparam int MAX_PRINTED = 40;

    logic signed [15:0] gain_q;
    logic [15:0]        knee_q;
    result_t            mapped_q[$];

    // one channel through the s-curve and the highlight knee
    function automatic logic [7:0] curve_byte(input logic [7:0] v,
                                              input logic signed [15:0] gain,
                                              input logic [15:0] knee);
        longint one, half, c, k, t, p, q, s;
        logic [127:0] over, span, bend;
        one  = longint'(1) << FRAC_BITS;
        half = longint'(1) << (FRAC_BITS - 1);
        c    = longint'(gain);
        k    = longint'({48'd0, knee}) << (FRAC_BITS - 16);
        // rounded up so that 255 lands on exactly one
        t    = ((longint'({56'd0, v}) << FRAC_BITS) + 254) / 255;
        p    = (t * (one - t)) >>> FRAC_BITS;
        q    = (p * (t - half)) / one;
        s    = t + (c * q) / 4096;
        if (s > k)
        begin
            over = 128'(s - k);
            span = 128'(one - k);
            bend = (over * span) / (span + over);
            s    = k + longint'(bend[63:0]);
        end
        if (s < 0)
            s = 0;
        if (s > one)
            s = one;
        return 8'((s * 255) >>> FRAC_BITS);
    endfunction

    function automatic result_t map_pixel(input pixel_t px);
        result_t r;
        r.red_out   = curve_byte(px.red_in, gain_q, knee_q);
        r.green_out = curve_byte(px.green_in, gain_q, knee_q);
        r.blue_out  = curve_byte(px.blue_in, gain_q, knee_q);
        r.alpha_out = px.alpha_in;
        r.last_out  = px.last_in;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            gain_q = CONTRAST_RESET;
            knee_q = KNEE_RESET;
            mapped_q.delete();
            mismatches = 0;
            in_flight = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (mapped_q.size() == 0)
                    report_mismatch("unexpected result, red", result.red_out, -1);
                else
                begin
                    want = mapped_q.pop_front();
                    if (result.red_out !== want.red_out)
                        report_mismatch("red", result.red_out, want.red_out);
                    if (result.green_out !== want.green_out)
                        report_mismatch("green", result.green_out, want.green_out);
                    if (result.blue_out !== want.blue_out)
                        report_mismatch("blue", result.blue_out, want.blue_out);
                    if (result.alpha_out !== want.alpha_out)
                        report_mismatch("alpha", result.alpha_out, want.alpha_out);
                    if (result.last_out !== want.last_out)
                        report_mismatch("last", result.last_out, want.last_out);
                end
            end
            if (start && !busy)
                mapped_q.push_back(map_pixel(pixel));
            // user must write registers only into an empty pipe
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CONTRAST_GAIN)
                    gain_q = cfg_data;
                else if (cfg_index == REG_KNEE_POINT)
                    knee_q = cfg_data;
            end
            in_flight = mapped_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import tcsk_pkg::*;

    localparam int FRAC_BITS   = 24;
    localparam int LATENCY     = FRAC_BITS + 7;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 232;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    pixel_t                 pixel;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     in_flight;
    int                     quiet_cycles;

    tone_curve_s_knee #(.FRAC_BITS(FRAC_BITS)) u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tone_curve_s_knee_checker #(.FRAC_BITS(FRAC_BITS)) u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // any transfer on any channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(190, 230));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t pick_pixel();
        pixel_t px;
        px.red_in   = pick_byte();
        px.green_in = pick_byte();
        px.blue_in  = pick_byte();
        px.alpha_in = 8'($urandom);
        px.last_in  = ($urandom_range(0, 15) == 0);
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px, input bit gappy);
        if (gappy && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        start <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold the sender until every mapped pixel is back and the pipe is empty
    task automatic drain();
        start <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    initial
    begin
        pixel_t corner_px[6];
        logic signed [15:0] gain;
        logic [15:0] knee;
        corner_px[0] = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
        corner_px[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
        corner_px[2] = '{8'd1, 8'd254, 8'd128, 8'h55, 1'b0};
        corner_px[3] = '{8'd127, 8'd64, 8'd192, 8'hAA, 1'b1};
        corner_px[4] = '{8'd204, 8'd205, 8'd230, 8'h0F, 1'b0};
        corner_px[5] = '{8'd32, 8'd96, 8'd160, 8'hF0, 1'b1};

        rst_n     = 1'b0;
        start     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners under reset settings, then the steepest curves with the knee at its ends
        foreach (corner_px[i])
            send_pixel(corner_px[i], 1'b0);
        drain();
        write_reg(REG_CONTRAST_GAIN, 16'h7FFF);
        write_reg(REG_KNEE_POINT, 16'h0000);
        foreach (corner_px[i])
            send_pixel(corner_px[i], 1'b0);
        drain();
        write_reg(REG_CONTRAST_GAIN, 16'h8000);
        write_reg(REG_KNEE_POINT, 16'hFFFF);
        // index past the register list must be dropped
        write_reg(CFG_INDEX_W'(REG_KNEE_POINT + 1), 16'h1234);
        write_reg('1, 16'hFFFF);
        foreach (corner_px[i])
            send_pixel(corner_px[i], 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    gain = 16'sh7FFF;
                    knee = 16'h0000;
                end
                1:
                begin
                    gain = 16'sh8000;
                    knee = 16'hFFFF;
                end
                2:
                begin
                    gain = CONTRAST_RESET;
                    knee = 16'h0000;
                end
                3:
                begin
                    gain = 16'sh1000;
                    knee = KNEE_RESET;
                end
                default:
                begin
                    gain = 16'($urandom);
                    knee = 16'($urandom);
                end
            endcase
            drain();
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_INDEX_W'($urandom_range(REG_KNEE_POINT + 1, (1 << CFG_INDEX_W) - 1)),
                          16'($urandom));
            write_reg(REG_CONTRAST_GAIN, gain);
            write_reg(REG_KNEE_POINT, knee);
            // no idling in the closing phase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(pick_pixel(), ph != PHASES - 1);
        end

        drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcsk_pkg.sv
rtl/tcsk_div.sv
rtl/tcsk_lane.sv
rtl/tone_curve_s_knee.sv
rtl/tcsk_checker.sv
tb/tone_curve_s_knee_checker.sv
tb/testbench.sv
